>>> src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define AM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also watches the reset cycles
`define AM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/agms_pkg.sv
package agms_pkg;

  // default sizes handed to the top level
  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;

  // fixed field widths of the beats
  localparam int CMD_W       = 3;
  localparam int VTX_W       = 4;
  localparam int IN_WEIGHT_W = 16;
  localparam int LIMIT_W     = 5;
  localparam int COUNT_OUT_W = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // input beat layout
  localparam int IN_CMD_LSB    = 0;
  localparam int IN_A_LSB      = 3;
  localparam int IN_B_LSB      = 7;
  localparam int IN_WEIGHT_LSB = 11;

  // result beat layout
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_WEIGHT_LSB = 1;
  localparam int OUT_COUNT_LSB  = 17;
  localparam int OUT_EMPTY_LSB  = 22;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTED_MODE = 2'd1;
  localparam logic [LIMIT_W-1:0]   VERTEX_LIMIT_RST  = 5'd16;

  // status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_VERTEX    = 3'd0,
    CMD_REMOVE_VERTEX = 3'd1,
    CMD_SET_EDGE      = 3'd2,
    CMD_REMOVE_EDGE   = 3'd3,
    CMD_READ_EDGE     = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLR_ROW,
    ST_CLR_COL,
    ST_MIRROR,
    ST_DONE
  } state_t;

endpackage

>>> src/adjacency_matrix_graph_store_core.sv
// channel | dir | handshake               | payload
// in_     | in  | in_tvalid / in_tready   | in_tdata: cmd, vertex_a, vertex_b, edge_weight
// out_    | out | out_tvalid / out_tready | out_tdata: status, weight_read, vertices_in_use,
//         |     |                         |   graph_empty
// cfg_    | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one command at a time; matrix writes share one write port, reads use one read port
// read, remove vertex, directed or self edge and failures go from execute to result;
// an undirected edge between two vertices adds a mirror write, and add vertex zeroes
// the new vertex's row and then its column, one entry per cycle
// reset clears state, in-use flags, count and config, not the matrix; no sweep after reset
// a finished result waits in the output register while the next command is taken
module adjacency_matrix_graph_store_core
  import agms_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] cmd, [6:3] vertex_a, [10:7] vertex_b, [26:11] edge_weight, rest zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] status, [16:1] weight_read, [21:17] vertices_in_use, [22] graph_empty,
  // [23] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int AW = 2 * VW;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  state_t state_r, state_nxt;

  logic [CMD_W-1:0]        cmd_r;
  logic [VTX_W-1:0]        a_r, b_r;
  logic [WEIGHT_BITS-1:0]  wt_r;
  logic [LIMIT_W-1:0]      vlimit_r;
  logic                    directed_r;
  logic [MAX_VERTICES-1:0] used_r;
  logic [CW-1:0]           count_r;
  logic [VW-1:0]           sweep_r;
  logic                    status_r;
  logic                    rd_sel_r;
  logic                    out_valid_r;
  logic [OUT_TDATA_W-1:0]  out_data_r;

  cmd_t                    cmd_e;
  logic [VW-1:0]           a_idx, b_idx;
  logic                    a_in, b_in, a_used, b_used, a_ok, b_ok;
  logic                    add_ok, edge_ok, cmd_ok;
  logic                    sweep_last;
  logic                    out_load;
  logic                    accept;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [WEIGHT_BITS-1:0]  ram_wdata, ram_rdata;

  logic signed [IN_WEIGHT_W-1:0] w_in_s;
  logic signed [31:0]            w_in_ext;
  logic signed [WEIGHT_BITS-1:0] rd_s;
  logic signed [31:0]            rd_ext;
  logic [IN_WEIGHT_W-1:0]        weight_out;

  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // weight in: sign-extend then keep the stored width
  assign w_in_s   = in_tdata[IN_WEIGHT_LSB +: IN_WEIGHT_W];
  assign w_in_ext = 32'(w_in_s);

  // vertex checks against limit, slot count and in-use map
  assign cmd_e   = cmd_t'(cmd_r);
  assign a_idx   = VW'(a_r);
  assign b_idx   = VW'(b_r);
  assign a_in    = ({1'b0, a_r} < vlimit_r) && (32'(a_r) < 32'(MAX_VERTICES));
  assign b_in    = ({1'b0, b_r} < vlimit_r) && (32'(b_r) < 32'(MAX_VERTICES));
  assign a_used  = used_r[a_idx];
  assign b_used  = used_r[b_idx];
  assign a_ok    = a_in && a_used;
  assign b_ok    = b_in && b_used;
  assign add_ok  = a_in && !a_used;
  assign edge_ok = a_ok && b_ok;

  always_comb begin
    unique case (cmd_e)
      CMD_ADD_VERTEX:    cmd_ok = add_ok;
      CMD_REMOVE_VERTEX: cmd_ok = a_ok;
      CMD_SET_EDGE:      cmd_ok = edge_ok;
      CMD_REMOVE_EDGE:   cmd_ok = edge_ok;
      CMD_READ_EDGE:     cmd_ok = edge_ok;
      default:           cmd_ok = 1'b0;
    endcase
  end

  assign sweep_last = (sweep_r == VW'(MAX_VERTICES - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (cmd_e)
          CMD_ADD_VERTEX: begin
            state_nxt = add_ok ? ST_CLR_ROW : ST_DONE;
          end
          CMD_SET_EDGE, CMD_REMOVE_EDGE: begin
            state_nxt = (edge_ok && !directed_r && (a_r != b_r)) ? ST_MIRROR : ST_DONE;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_CLR_ROW: begin
        if (sweep_last) state_nxt = ST_CLR_COL;
      end
      ST_CLR_COL: begin
        if (sweep_last) state_nxt = ST_DONE;
      end
      ST_MIRROR: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: matrix port and handshakes
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = {a_idx, b_idx};
    ram_raddr = {a_idx, b_idx};
    ram_wdata = '0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_EXEC: begin
        if (edge_ok) begin
          unique case (cmd_e)
            CMD_SET_EDGE: begin
              ram_we    = 1'b1;
              ram_wdata = wt_r;
            end
            CMD_REMOVE_EDGE: ram_we = 1'b1;
            CMD_READ_EDGE:   ram_re = 1'b1;
            default: ;
          endcase
        end
      end
      ST_CLR_ROW: begin
        ram_we    = 1'b1;
        ram_waddr = {a_idx, sweep_r};
      end
      ST_CLR_COL: begin
        ram_we    = 1'b1;
        ram_waddr = {sweep_r, a_idx};
      end
      ST_MIRROR: begin
        ram_we    = 1'b1;
        ram_waddr = {b_idx, a_idx};
        ram_wdata = (cmd_e == CMD_SET_EDGE) ? wt_r : '0;
      end
      ST_DONE: out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_tdata[IN_CMD_LSB +: CMD_W];
      a_r   <= in_tdata[IN_A_LSB +: VTX_W];
      b_r   <= in_tdata[IN_B_LSB +: VTX_W];
      wt_r  <= w_in_ext[WEIGHT_BITS-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlimit_r   <= VERTEX_LIMIT_RST;
      directed_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VERTEX_LIMIT:  vlimit_r   <= cfg_data[LIMIT_W-1:0];
        CFG_DIRECTED_MODE: directed_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // in-use map and vertex count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      count_r <= '0;
    end else if (state_r == ST_EXEC) begin
      if (cmd_e == CMD_ADD_VERTEX && add_ok) begin
        used_r[a_idx] <= 1'b1;
        count_r       <= count_r + CW'(1);
      end else if (cmd_e == CMD_REMOVE_VERTEX && a_ok) begin
        used_r[a_idx] <= 1'b0;
        count_r       <= count_r - CW'(1);
      end
    end
  end

  // status, read select and sweep index
  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      status_r <= cmd_ok ? STATUS_OK : STATUS_FAIL;
      rd_sel_r <= (cmd_e == CMD_READ_EDGE) && edge_ok;
      sweep_r  <= '0;
    end else if (state_r == ST_CLR_ROW || state_r == ST_CLR_COL) begin
      sweep_r  <= sweep_last ? '0 : sweep_r + VW'(1);
    end
  end

  // weight out: sign-extend the stored width, keep the low field bits
  assign rd_s       = ram_rdata;
  assign rd_ext     = 32'(rd_s);
  assign weight_out = rd_sel_r ? rd_ext[IN_WEIGHT_W-1:0] : '0;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {1'b0, (count_r == '0), COUNT_OUT_W'(count_r), weight_out, status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  agms_matrix_ram #(
    .AW (AW),
    .DW (WEIGHT_BITS)
  ) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> src/agms_matrix_ram.sv
module agms_matrix_ram
  import agms_pkg::*;
#(
  parameter int AW = 8,
  parameter int DW = WEIGHT_BITS_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];
  logic [DW-1:0] rdata_r;

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/agms_checker.sv
`include "assert_macros.svh"

module agms_checker
  import agms_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  `AM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // no result beat right after reset
  `AM_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_tvalid, "result beat valid after reset")

  // a command keeps the block busy for the following cycle
  `AM_ASSERT(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "input ready right after an accepted beat")

  // empty flag agrees with the vertex count
  `AM_ASSERT(a_empty_flag, out_tvalid |-> (out_tdata[OUT_EMPTY_LSB] == (out_tdata[OUT_COUNT_LSB +: COUNT_OUT_W] == '0)), "graph_empty disagrees with vertex count")

  // a failed command returns no weight
  `AM_ASSERT(a_fail_no_weight, out_tvalid && (out_tdata[OUT_STATUS_LSB] == STATUS_FAIL) |-> (out_tdata[OUT_WEIGHT_LSB +: IN_WEIGHT_W] == '0), "weight returned on failure")

endmodule

bind adjacency_matrix_graph_store_core agms_checker u_agms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
